// ===== rtl/core/gkc_pkg.sv =====
// ----------------------------------------------------------------------------
// gkc_pkg: shared types and constants for the grid kernel convolution unit
// Field widths, operation and register codes, sequencer states, and the
// control bundle that drives the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package gkc_pkg;

    // payload field widths
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 6;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SUM_W     = 40;

    // configuration register widths
    localparam int DIM_W     = 7;
    localparam int KSZ_W     = 3;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    // default store sizes
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_KERNEL_DEF = 7;

    // configuration reset values
    localparam logic [DIM_W-1:0] HEIGHT_RST = 7'd64;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 7'd64;
    localparam logic [KSZ_W-1:0] KSIZE_RST  = 3'd3;
    localparam logic             WRAP_RST   = 1'b1;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_WR_KERNEL = 2'd0,
        FN_WR_CELL   = 2'd1,
        FN_SUM       = 2'd2,
        FN_SWAP      = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_KSIZE  = 2'd2,
        CFG_WRAP   = 2'd3
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TAPS,
        ST_DRAIN
    } state_t;

    // control for the multiply-accumulate pipeline
    typedef struct packed {
        logic clr;   // start of a new sum, clears the accumulator
        logic busy;  // a tap is in the read data stage
        logic ok;    // that tap lies inside the grid and contributes
    } mac_ctrl_t;

endpackage

// ===== rtl/core/gkc_mac.sv =====
// ----------------------------------------------------------------------------
// gkc_mac: multiply-accumulate pipeline for kernel taps
// One registered 16x16 signed product per cycle, then an exact 40-bit
// accumulate. Taps outside the grid enter as a zero product.
// ----------------------------------------------------------------------------
module gkc_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gkc_pkg::mac_ctrl_t                    ctrl,
    input  logic signed [gkc_pkg::VAL_W-1:0]      grid_val,
    input  logic signed [gkc_pkg::VAL_W-1:0]      coef,
    output logic signed [gkc_pkg::SUM_W-1:0]      acc,
    output logic                                  busy
);
    import gkc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     pbusy_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;

    // product stage, gated for taps that add nothing
    always_comb
    begin
        if (ctrl.ok)
        begin
            prod_next = grid_val * coef;
        end
        else
        begin
            prod_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // accumulate stage
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (pbusy_reg)
        begin
            acc_next = acc_reg + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pbusy_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            pbusy_reg <= ctrl.busy;
            acc_reg   <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign busy = pbusy_reg;

endmodule

// ===== rtl/core/grid_kernel_convolution_unit.sv =====
// ----------------------------------------------------------------------------
// grid_kernel_convolution_unit: double-buffered grid with kernel convolution
// Holds two cell banks and a square kernel; returns the weighted
// neighbourhood sum of one cell of the front bank, with torus or zero edges.
// ----------------------------------------------------------------------------
// Usage
// - input channel (in_valid/in_stall): func, row, col, value. Kernel writes,
//   back-bank cell writes and bank swaps take effect at the transfer.
// - a sum request returns one transfer on the output channel (sum, cell_row,
//   cell_col); a request outside the grid in use returns nothing.
// - a sum walks the kernel taps one per cycle through the grid and kernel
//   memory read ports, then a two-stage multiply-accumulate pipeline. The
//   next item is taken once the sum is in the output register.
// - the output register holds its result while out_stall is high; writes
//   and swaps go on meanwhile, a further sum runs its taps and then waits,
//   with in_stall high, until the result is taken.
// - configuration port (wr_en/wr_index/wr_data) is written while idle.
// - after reset both banks and the kernel are cleared one entry a cycle;
//   in_stall stays high during that clearing pass.
// ----------------------------------------------------------------------------
module grid_kernel_convolution_unit #(
    parameter int MAX_HEIGHT = gkc_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = gkc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = gkc_pkg::MAX_KERNEL_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [gkc_pkg::FUNC_W-1:0]            func,
    input  logic [gkc_pkg::POS_W-1:0]             row,
    input  logic [gkc_pkg::POS_W-1:0]             col,
    input  logic signed [gkc_pkg::VAL_W-1:0]      value,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [gkc_pkg::SUM_W-1:0]      sum,
    output logic [gkc_pkg::POS_W-1:0]             cell_row,
    output logic [gkc_pkg::POS_W-1:0]             cell_col,
    // configuration port
    input  logic                                  wr_en,
    input  logic [gkc_pkg::CFG_IDX_W-1:0]         wr_index,
    input  logic [gkc_pkg::CFG_W-1:0]             wr_data
);
    import gkc_pkg::*;

    // address and counter widths
    localparam int RW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KW        = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int GAW       = 1 + RW + CW;
    localparam int KAW       = 2 * KW;
    localparam int GDEPTH    = 2 ** GAW;
    localparam int KDEPTH    = 2 ** KAW;
    localparam int CLR_DEPTH = (GDEPTH > KDEPTH) ? GDEPTH : KDEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int KCW       = (KW > KSZ_W) ? KW : KSZ_W;
    localparam int MW1       = (DIM_W > RW) ? DIM_W : RW;
    localparam int MW2       = (MW1 > CW) ? MW1 : CW;
    localparam int CRD_W     = MW2 + 2;

    // configuration registers
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] width_reg;
    logic [KSZ_W-1:0] ksize_reg;
    logic             wrap_reg;

    // control state
    state_t           state_reg;
    state_t           state_next;
    logic [CLR_W-1:0] clr_cnt_reg;
    logic [CLR_W-1:0] clr_cnt_next;
    logic             front_reg;
    logic             front_next;
    logic [KW-1:0]    kx_reg;
    logic [KW-1:0]    kx_next;
    logic [KW-1:0]    ky_reg;
    logic [KW-1:0]    ky_next;
    logic             tap_busy_reg;
    logic             tap_ok_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    // request payload
    logic [POS_W-1:0]        row_reg;
    logic [POS_W-1:0]        col_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [POS_W-1:0]        cell_row_reg;
    logic [POS_W-1:0]        cell_col_reg;

    // memories
    logic signed [VAL_W-1:0] grid_mem [GDEPTH];
    logic signed [VAL_W-1:0] kern_mem [KDEPTH];
    logic signed [VAL_W-1:0] grid_rd_reg;
    logic signed [VAL_W-1:0] kern_rd_reg;
    logic                    grid_we;
    logic [GAW-1:0]          grid_waddr;
    logic signed [VAL_W-1:0] grid_wdata;
    logic [GAW-1:0]          grid_raddr;
    logic                    kern_we;
    logic [KAW-1:0]          kern_waddr;
    logic signed [VAL_W-1:0] kern_wdata;
    logic [KAW-1:0]          kern_raddr;

    // sequencer strobes
    logic      in_stall_c;
    logic      start;
    logic      tap_issue;
    logic      out_load;
    logic      tap_ok;

    // effective dimensions
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] w_eff;
    logic [KSZ_W-1:0] ks_eff;
    logic [KSZ_W-1:0] rad;
    logic [KCW-1:0]   ks_m1;
    logic             last_x;
    logic             last_y;

    // tap coordinates
    logic signed [CRD_W-1:0] ay_raw;
    logic signed [CRD_W-1:0] ax_raw;
    logic signed [CRD_W-1:0] ay_w;
    logic signed [CRD_W-1:0] ax_w;
    logic signed [CRD_W-1:0] h_s;
    logic signed [CRD_W-1:0] w_s;

    mac_ctrl_t               mac_ctrl;
    logic signed [SUM_W-1:0] mac_acc;
    logic                    mac_busy;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= HEIGHT_RST;
            width_reg  <= WIDTH_RST;
            ksize_reg  <= KSIZE_RST;
            wrap_reg   <= WRAP_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_HEIGHT: height_reg <= wr_data[DIM_W-1:0];
                CFG_WIDTH:  width_reg  <= wr_data[DIM_W-1:0];
                CFG_KSIZE:  ksize_reg  <= wr_data[KSZ_W-1:0];
                CFG_WRAP:   wrap_reg   <= wr_data[0];
                default:    ;
            endcase
        end
    end

    // clamp the dimensions to the stores
    always_comb
    begin
        if (height_reg == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end

        if (width_reg == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end

        if (int'(ksize_reg) > MAX_KERNEL)
        begin
            ks_eff = KSZ_W'(MAX_KERNEL);
        end
        else
        begin
            ks_eff = ksize_reg;
        end
    end

    assign rad    = ks_eff >> 1;
    assign ks_m1  = KCW'(ks_eff - KSZ_W'(1));
    assign last_x = (KCW'(kx_reg) == ks_m1);
    assign last_y = (KCW'(ky_reg) == ks_m1);

    // neighbour position with one wrap, and its in-grid check
    always_comb
    begin
        h_s    = $signed(CRD_W'(h_eff));
        w_s    = $signed(CRD_W'(w_eff));
        ay_raw = $signed(CRD_W'(row_reg)) + $signed(CRD_W'(ky_reg)) - $signed(CRD_W'(rad));
        ax_raw = $signed(CRD_W'(col_reg)) + $signed(CRD_W'(kx_reg)) - $signed(CRD_W'(rad));
        ay_w   = ay_raw;
        ax_w   = ax_raw;
        if (wrap_reg)
        begin
            if (ay_raw < 0)
            begin
                ay_w = ay_raw + h_s;
            end
            else if (ay_raw >= h_s)
            begin
                ay_w = ay_raw - h_s;
            end
            if (ax_raw < 0)
            begin
                ax_w = ax_raw + w_s;
            end
            else if (ax_raw >= w_s)
            begin
                ax_w = ax_raw - w_s;
            end
        end
        tap_ok     = (ay_w >= 0) && (ay_w < h_s) && (ax_w >= 0) && (ax_w < w_s);
        grid_raddr = {front_reg, ay_w[RW-1:0], ax_w[CW-1:0]};
        kern_raddr = {ky_reg, kx_reg};
    end

    // sequencer: next state, memory writes and strobes
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        front_next   = front_reg;
        kx_next      = kx_reg;
        ky_next      = ky_reg;
        in_stall_c   = 1'b1;
        start        = 1'b0;
        tap_issue    = 1'b0;
        out_load     = 1'b0;
        grid_we      = 1'b0;
        grid_waddr   = {~front_reg, RW'(row), CW'(col)};
        grid_wdata   = value;
        kern_we      = 1'b0;
        kern_waddr   = {row[KW-1:0], col[KW-1:0]};
        kern_wdata   = value;

        unique case (state_reg)
            ST_CLEAR:
            begin
                grid_we    = 1'b1;
                grid_waddr = GAW'(clr_cnt_reg);
                grid_wdata = '0;
                kern_we    = 1'b1;
                kern_waddr = KAW'(clr_cnt_reg);
                kern_wdata = '0;
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                end
            end

            ST_IDLE:
            begin
                in_stall_c = 1'b0;
                if (in_valid)
                begin
                    unique case (func_t'(func))
                        FN_WR_KERNEL:
                        begin
                            kern_we = (int'(row) < MAX_KERNEL) && (int'(col) < MAX_KERNEL);
                        end
                        FN_WR_CELL:
                        begin
                            grid_we = (int'(row) < MAX_HEIGHT) && (int'(col) < MAX_WIDTH);
                        end
                        FN_SWAP:
                        begin
                            front_next = ~front_reg;
                        end
                        FN_SUM:
                        begin
                            if ((DIM_W'(row) < h_eff) && (DIM_W'(col) < w_eff))
                            begin
                                start   = 1'b1;
                                kx_next = '0;
                                ky_next = '0;
                                if (ks_eff == '0)
                                begin
                                    state_next = ST_DRAIN;
                                end
                                else
                                begin
                                    state_next = ST_TAPS;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_TAPS:
            begin
                tap_issue = 1'b1;
                if (last_x)
                begin
                    kx_next = '0;
                    ky_next = ky_reg + KW'(1);
                    if (last_y)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    kx_next = kx_reg + KW'(1);
                end
            end

            ST_DRAIN:
            begin
                if (!tap_busy_reg && !mac_busy && (!out_valid_reg || !out_stall))
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            front_reg     <= 1'b0;
            kx_reg        <= '0;
            ky_reg        <= '0;
            tap_busy_reg  <= 1'b0;
            tap_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            front_reg     <= front_next;
            kx_reg        <= kx_next;
            ky_reg        <= ky_next;
            tap_busy_reg  <= tap_issue;
            tap_ok_reg    <= tap_issue && tap_ok;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg <= row;
            col_reg <= col;
        end
        if (out_load)
        begin
            sum_reg      <= mac_acc;
            cell_row_reg <= row_reg;
            cell_col_reg <= col_reg;
        end
    end

    // grid memory, both banks, bank select in the top address bit
    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        grid_rd_reg <= grid_mem[grid_raddr];
    end

    // kernel coefficient memory
    always_ff @(posedge clk)
    begin
        if (kern_we)
        begin
            kern_mem[kern_waddr] <= kern_wdata;
        end
        kern_rd_reg <= kern_mem[kern_raddr];
    end

    // multiply-accumulate pipeline
    assign mac_ctrl.clr  = start;
    assign mac_ctrl.busy = tap_busy_reg;
    assign mac_ctrl.ok   = tap_ok_reg;

    gkc_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .grid_val (grid_rd_reg),
        .coef     (kern_rd_reg),
        .acc      (mac_acc),
        .busy     (mac_busy)
    );

    assign in_stall  = in_stall_c;
    assign out_valid = out_valid_reg;
    assign sum       = sum_reg;
    assign cell_row  = cell_row_reg;
    assign cell_col  = cell_col_reg;

    // a new sum only starts with the tap pipeline empty
    a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (!tap_busy_reg && !mac_busy))
        else $error("sum started with taps still in flight");

    // taps reach the read data stage only from the tap walk
    a_tap_origin: assert property (@(posedge clk) disable iff (!rst_n)
        tap_busy_reg |-> $past(state_reg == ST_TAPS))
        else $error("tap in flight outside the tap walk");

    // a result is loaded only once the accumulator holds every tap
    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!tap_busy_reg && !mac_busy && state_reg == ST_DRAIN))
        else $error("result loaded before the pipeline drained");

    // no memory clear write is left once items are taken
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && $past(state_reg == ST_CLEAR))
            |-> $past(clr_cnt_reg == CLR_W'(CLR_DEPTH - 1)))
        else $error("clearing pass left early");

endmodule

// ===== test/grid_kernel_convolution_unit_test.sv =====
// ----------------------------------------------------------------------------
// grid_kernel_convolution_unit_test: self-checking bench for the convolution unit
// Drives kernel writes, back-bank cell writes, bank swaps and sum requests,
// keeps its own copy of both banks, the kernel and the configuration registers, and
// compares every returned sum and cell position with the predicted one.
// ----------------------------------------------------------------------------
module grid_kernel_convolution_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gkc_pkg::*;

    localparam int ROWS = MAX_HEIGHT_DEF;
    localparam int COLS = MAX_WIDTH_DEF;
    localparam int KMAX = MAX_KERNEL_DEF;
    localparam int IDLE_PCT = 26;
    // settling wait once the last result is out
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        logic signed [SUM_W-1:0] total;
        logic [POS_W-1:0]        r;
        logic [POS_W-1:0]        c;
    } cell_sum_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func = '0;
    logic [POS_W-1:0]         row = '0;
    logic [POS_W-1:0]         col = '0;
    logic signed [VAL_W-1:0]  value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [SUM_W-1:0]  sum;
    logic [POS_W-1:0]         cell_row;
    logic [POS_W-1:0]         cell_col;
    logic                     wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     wr_index = '0;
    logic [CFG_W-1:0]         wr_data = '0;

    // shadow copy of the block state
    logic signed [VAL_W-1:0]  cell_banks [2][ROWS*COLS];
    logic signed [VAL_W-1:0]  coeffs [KMAX*KMAX];
    logic                     front_sel;
    logic [DIM_W-1:0]         rows_reg;
    logic [DIM_W-1:0]         cols_reg;
    logic [KSZ_W-1:0]         ksize_reg;
    logic                     wrap_reg;

    cell_sum_t                expected_sums [$];
    int                       mismatches = 0;
    bit                       steady = 1'b0;

    grid_kernel_convolution_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum       (sum),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // size register as the block uses it: zero counts as one, clipped at the store
    function automatic int used_dim(logic [DIM_W-1:0] reg_val, int limit);
        if (reg_val == 0)
            return 1;
        if (reg_val > limit)
            return limit;
        return reg_val;
    endfunction

    // weighted neighborhood sum of one front-bank cell
    function automatic logic signed [SUM_W-1:0] weighted_sum(int r, int c);
        int     h;
        int     w;
        int     ks;
        int     rad;
        int     ay;
        int     ax;
        longint acc;
        h = used_dim(rows_reg, ROWS);
        w = used_dim(cols_reg, COLS);
        ks = (ksize_reg > KMAX) ? KMAX : ksize_reg;
        rad = ks / 2;
        acc = 0;
        for (int y = 0; y < ks; y++)
        begin
            for (int x = 0; x < ks; x++)
            begin
                ay = r + y - rad;
                ax = c + x - rad;
                // torus mode wraps once only
                if (wrap_reg)
                begin
                    if (ay < 0)
                        ay += h;
                    else if (ay >= h)
                        ay -= h;
                    if (ax < 0)
                        ax += w;
                    else if (ax >= w)
                        ax -= w;
                end
                if (ay >= 0 && ay < h && ax >= 0 && ax < w)
                    acc += longint'(cell_banks[front_sel][ay*COLS+ax]) *
                           longint'(coeffs[y*KMAX+x]);
            end
        end
        return acc[SUM_W-1:0];
    endfunction

    // update the shadow state for one accepted item
    task automatic apply_item(func_t f, int r, int c, logic signed [VAL_W-1:0] v);
        cell_sum_t e;
        case (f)
            FN_WR_KERNEL:
                if (r < KMAX && c < KMAX)
                    coeffs[r*KMAX+c] = v;
            FN_WR_CELL:
                if (r < ROWS && c < COLS)
                    cell_banks[!front_sel][r*COLS+c] = v;
            FN_SUM:
                if (r < used_dim(rows_reg, ROWS) && c < used_dim(cols_reg, COLS))
                begin
                    e.total = weighted_sum(r, c);
                    e.r = r[POS_W-1:0];
                    e.c = c[POS_W-1:0];
                    expected_sums.push_back(e);
                end
            FN_SWAP:
                front_sel = !front_sel;
        endcase
    endtask

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(func_t f, int r, int c, logic [VAL_W-1:0] v);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        row <= r[POS_W-1:0];
        col <= c[POS_W-1:0];
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_item(f, r, c, v);
    endtask

    // drop valid, let every result drain and the unit settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] d);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= d;
        @(posedge clk);
        case (idx)
            CFG_HEIGHT: rows_reg = d[DIM_W-1:0];
            CFG_WIDTH:  cols_reg = d[DIM_W-1:0];
            CFG_KSIZE:  ksize_reg = d[KSZ_W-1:0];
            CFG_WRAP:   wrap_reg = d[0];
        endcase
    endtask

    task automatic set_grid(int h, int w, int k, int wrp);
        wait_idle();
        write_reg(CFG_HEIGHT, CFG_W'(h));
        write_reg(CFG_WIDTH, CFG_W'(w));
        write_reg(CFG_KSIZE, CFG_W'(k));
        write_reg(CFG_WRAP, CFG_W'(wrp));
        wr_en <= 1'b0;
    endtask

    // position biased toward the wrap seam, sometimes anywhere in the field
    function automatic int pick_pos(int limit);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return $urandom_range(0, 63);
        if (pick < 58)
            return (limit * 4 - 3 + $urandom_range(0, 5)) % limit;
        return $urandom_range(0, limit - 1);
    endfunction

    task automatic send_random_item();
        int                pick;
        int                h;
        int                w;
        func_t             f;
        logic [VAL_W-1:0]  v;
        h = used_dim(rows_reg, ROWS);
        w = used_dim(cols_reg, COLS);
        v = VAL_W'($urandom);
        if ($urandom_range(0, 6) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       v = 16'h8000;
                1:       v = 16'h7fff;
                2:       v = 16'h0000;
                default: v = 16'hffff;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 12)
            send_item(FN_WR_KERNEL, pick_pos(KMAX), pick_pos(KMAX), v);
        else
        begin
            if (pick < 50)
                f = FN_WR_CELL;
            else if (pick < 88)
                f = FN_SUM;
            else
                f = FN_SWAP;
            send_item(f, pick_pos(h), pick_pos(w), v);
        end
    endtask

    // cleared stores, extreme values, ignored writes, both banks, corner wrap
    task automatic test_power_on_sums();
        send_item(FN_SUM, 0, 0, 16'h5a5a);
        send_item(FN_WR_KERNEL, 0, 0, 16'h8000);
        send_item(FN_WR_KERNEL, 6, 6, 16'h7fff);
        send_item(FN_WR_KERNEL, 1, 1, 16'h0100);
        send_item(FN_WR_KERNEL, 0, 2, 16'hffff);
        send_item(FN_WR_KERNEL, 7, 3, 16'h1234);
        send_item(FN_WR_KERNEL, 2, 63, 16'h4321);
        send_item(FN_WR_CELL, 0, 0, 16'h7fff);
        send_item(FN_WR_CELL, 63, 63, 16'h8000);
        send_item(FN_WR_CELL, 0, 63, 16'h0100);
        send_item(FN_WR_CELL, 63, 0, 16'hffff);
        send_item(FN_WR_CELL, 1, 1, 16'h0200);
        send_item(FN_SUM, 0, 0, 16'h0000);
        send_item(FN_SWAP, 21, 42, 16'ha5a5);
        send_item(FN_SUM, 0, 0, 16'hffff);
        send_item(FN_SUM, 63, 63, 16'h0000);
        send_item(FN_SUM, 0, 63, 16'h0000);
        send_item(FN_SUM, 63, 0, 16'h0000);
        send_item(FN_SUM, 1, 1, 16'h0000);
        send_item(FN_WR_CELL, 0, 0, 16'h8000);
        send_item(FN_SWAP, 0, 0, 16'h0000);
        send_item(FN_SUM, 0, 0, 16'h0000);
        send_item(FN_SWAP, 63, 63, 16'hffff);
        send_item(FN_SUM, 63, 63, 16'h0000);
    endtask

    // zero and oversized registers, no taps, edge mode, requests off the grid
    task automatic test_size_limits();
        set_grid(0, 0, 7, 1);
        send_item(FN_SUM, 0, 0, 16'h0000);
        send_item(FN_SUM, 0, 1, 16'h0000);
        send_item(FN_SUM, 63, 63, 16'h0000);
        set_grid(127, 127, 0, 0);
        send_item(FN_SUM, 0, 0, 16'h0000);
        send_item(FN_SUM, 63, 63, 16'h0000);
        set_grid(64, 64, 7, 0);
        send_item(FN_SUM, 0, 0, 16'h0000);
        send_item(FN_SUM, 63, 63, 16'h0000);
        set_grid(1, 64, 6, 1);
        send_item(FN_SUM, 0, 10, 16'h0000);
        send_item(FN_SUM, 1, 0, 16'h0000);
    endtask

    task automatic run_phase(int h, int w, int k, int wrp, int count);
        set_grid(h, w, k, wrp);
        repeat (count) send_random_item();
    endtask

    // random traffic across a range of grid shapes and kernel sizes
    task automatic test_random_phases();
        run_phase(64, 64, 7, 1, 118);
        run_phase(5, 7, 3, 1, 118);
        run_phase(1, 1, 7, 1, 118);
        run_phase(2, 3, 7, 0, 118);
        // one stretch with no idling on either side
        steady = 1'b1;
        run_phase(2, 2, 6, 1, 118);
        steady = 1'b0;
        run_phase(64, 64, 4, 0, 118);
        run_phase(13, 9, 5, 1, 118);
        run_phase(127, 100, 2, 0, 118);
        run_phase(0, 64, 1, 1, 118);
        run_phase(3, 64, 0, 1, 118);
        run_phase(64, 1, 7, 0, 118);
        run_phase(7, 6, 7, 1, 118);
    endtask

    task automatic note_error(string what, longint want, longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    // result checker and output stall
    initial
    begin
        cell_sum_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_sums.size() == 0)
                    note_error("unrequested result, sum", 0, sum);
                else
                begin
                    e = expected_sums.pop_front();
                    if (sum !== e.total)
                        note_error("sum", e.total, sum);
                    if (cell_row !== e.r)
                        note_error("cell_row", e.r, cell_row);
                    if (cell_col !== e.c)
                        note_error("cell_col", e.c, cell_col);
                end
            end
            out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // main sequence
    initial
    begin
        for (int i = 0; i < ROWS * COLS; i++)
        begin
            cell_banks[0][i] = '0;
            cell_banks[1][i] = '0;
        end
        for (int i = 0; i < KMAX * KMAX; i++)
            coeffs[i] = '0;
        front_sel = 1'b0;
        rows_reg = HEIGHT_RST;
        cols_reg = WIDTH_RST;
        ksize_reg = KSIZE_RST;
        wrap_reg = WRAP_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_power_on_sums();
        test_size_limits();
        test_random_phases();
        wait_idle();

        if (mismatches == 0)
            $display("grid_kernel_convolution_unit_test passed");
        else
            $display("grid_kernel_convolution_unit_test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("grid_kernel_convolution_unit_test failed");
        $finish;
    end

endmodule

// ===== grid_kernel_convolution_unit.f =====
rtl/core/gkc_pkg.sv
rtl/core/gkc_mac.sv
rtl/core/grid_kernel_convolution_unit.sv
test/grid_kernel_convolution_unit_test.sv
